[hw/rtl/ilep_pkg.sv]
// ----------------------------------------------------------------------------
// Item location extent parser package
// Shared types and constants: the request and response payloads, the parse
// phase encoding and the parser state record.
// ----------------------------------------------------------------------------
package ilep_pkg;

   // Address width kept on offsets, lengths and bases.
   localparam int AddrWidth = 64;
   localparam logic [63:0] AddrMask = {64{1'b1}} >> (64 - AddrWidth);

   // Header byte positions within the first six payload bytes.
   localparam logic [3:0] HdrVersionByte = 4'd0;
   localparam logic [3:0] HdrSizeByte    = 4'd4;
   localparam logic [3:0] HdrBaseByte    = 4'd5;

   // Construction method handling.
   localparam logic [63:0] MethodMask = 64'h0F;
   localparam logic [3:0]  MethodIdat = 4'd1;

   // Version codes that carry the method field and the index width.
   localparam logic [7:0] Version1 = 8'd1;
   localparam logic [7:0] Version2 = 8'd2;

   // Parse phases, one-hot.
   typedef enum logic [10:0] {
      PhHeader    = 11'b000_0000_0001,
      PhCount     = 11'b000_0000_0010,
      PhId        = 11'b000_0000_0100,
      PhMethod    = 11'b000_0000_1000,
      PhDref      = 11'b000_0001_0000,
      PhBase      = 11'b000_0010_0000,
      PhExtCount  = 11'b000_0100_0000,
      PhExtIndex  = 11'b000_1000_0000,
      PhExtOffset = 11'b001_0000_0000,
      PhExtLength = 11'b010_0000_0000,
      PhTail      = 11'b100_0000_0000
   } phase_type;

   // One request: a payload byte and its last-byte mark.
   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   // One response: an extent record and/or the done report.
   typedef struct packed {
      logic        extent_valid;
      logic [31:0] item_id;
      logic [63:0] extent_offset;
      logic [63:0] extent_length;
      logic        from_item_data;
      logic [15:0] extent_index;
      logic        done_res;
      logic        status;
   } rsp_type;

   // Parser state carried from byte to byte.
   typedef struct packed {
      phase_type   phase;
      logic [7:0]  box_version;
      logic [3:0]  offset_width;
      logic [3:0]  length_width;
      logic [3:0]  base_width;
      logic [3:0]  index_width;
      logic [3:0]  bytes_in_field;
      logic [63:0] accumulator;
      logic [31:0] items_left;
      logic [15:0] extents_left;
      logic [31:0] current_id;
      logic [3:0]  current_method;
      logic [63:0] base_value;
      logic [63:0] offset_value;
      logic [15:0] extent_counter;
   } state_type;

   localparam state_type StateInit = '{phase: PhHeader, default: '0};

endpackage

[hw/rtl/ilep_step.sv]
// ----------------------------------------------------------------------------
// Item location extent parser step
// Next-state and response logic for one payload byte: field accumulation,
// field completion and the skipping of zero-width fields.
// ----------------------------------------------------------------------------
module ilep_step (
   input  ilep_pkg::state_type st,
   input  ilep_pkg::req_type   req,
   output ilep_pkg::state_type st_next,
   output logic                rsp_present,
   output ilep_pkg::rsp_type   rsp
);

   logic                ver12;
   logic                ver_small;
   logic                zero_ext;
   logic [3:0]          need;
   logic [3:0]          bif_inc;
   logic [63:0]         acc_shift;
   ilep_pkg::state_type work;
   logic                finish;
   logic                rec_vld;
   logic [63:0]         rec_off_op;
   logic [63:0]         rec_len;
   logic [15:0]         rec_idx;
   logic [31:0]         items_dec;
   logic [15:0]         left_dec;

   assign ver12     = (st.box_version == ilep_pkg::Version1) ||
                      (st.box_version == ilep_pkg::Version2);
   assign ver_small = (st.box_version < ilep_pkg::Version2);
   assign zero_ext  = (st.index_width == 4'd0) && (st.offset_width == 4'd0) &&
                      (st.length_width == 4'd0);
   assign acc_shift = {st.accumulator[55:0], req.byte_value};
   assign bif_inc   = st.bytes_in_field + 4'd1;
   assign left_dec  = st.extents_left - 16'd1;

   // Byte count of the field being read in the current phase.
   always_comb begin
      case (st.phase)
         ilep_pkg::PhCount, ilep_pkg::PhId: need = ver_small ? 4'd2 : 4'd4;
         ilep_pkg::PhMethod:    need = ver12 ? 4'd2 : 4'd0;
         ilep_pkg::PhDref:      need = 4'd2;
         ilep_pkg::PhBase:      need = st.base_width;
         ilep_pkg::PhExtCount:  need = 4'd2;
         ilep_pkg::PhExtIndex:  need = st.index_width;
         ilep_pkg::PhExtOffset: need = st.offset_width;
         ilep_pkg::PhExtLength: need = st.length_width;
         default:               need = 4'd1;
      endcase
   end

   // Byte consumption, field completion, then the zero-width field chain.
   always_comb begin
      work       = st;
      finish     = 1'b0;
      rec_vld    = 1'b0;
      rec_off_op = '0;
      rec_len    = '0;
      rec_idx    = '0;

      case (st.phase)
         ilep_pkg::PhHeader: begin
            if (st.bytes_in_field == ilep_pkg::HdrVersionByte) begin
               work.box_version = req.byte_value;
            end
            if (st.bytes_in_field == ilep_pkg::HdrSizeByte) begin
               work.offset_width = req.byte_value[7:4];
               work.length_width = req.byte_value[3:0];
            end
            if (st.bytes_in_field == ilep_pkg::HdrBaseByte) begin
               work.base_width     = req.byte_value[7:4];
               work.index_width    = ver12 ? req.byte_value[3:0] : 4'd0;
               work.phase          = ilep_pkg::PhCount;
               work.accumulator    = '0;
               work.bytes_in_field = '0;
            end else begin
               work.bytes_in_field = bif_inc;
            end
         end
         ilep_pkg::PhTail: begin
            // Trailing bytes after the last item are ignored.
            work = st;
         end
         default: begin
            work.accumulator    = acc_shift;
            work.bytes_in_field = bif_inc;
            if (bif_inc >= need) begin
               work.accumulator    = '0;
               work.bytes_in_field = '0;
               case (st.phase)
                  ilep_pkg::PhCount: begin
                     work.items_left = acc_shift[31:0];
                     work.phase = (acc_shift[31:0] == 32'd0) ? ilep_pkg::PhTail
                                                            : ilep_pkg::PhId;
                  end
                  ilep_pkg::PhId: begin
                     work.current_id     = acc_shift[31:0];
                     work.current_method = 4'd0;
                     work.phase          = ilep_pkg::PhMethod;
                  end
                  ilep_pkg::PhMethod: begin
                     work.current_method = 4'(acc_shift & ilep_pkg::MethodMask);
                     work.phase          = ilep_pkg::PhDref;
                  end
                  ilep_pkg::PhDref: begin
                     work.phase = ilep_pkg::PhBase;
                  end
                  ilep_pkg::PhBase: begin
                     work.base_value = acc_shift & ilep_pkg::AddrMask;
                     work.phase      = ilep_pkg::PhExtCount;
                  end
                  ilep_pkg::PhExtCount: begin
                     work.extents_left   = acc_shift[15:0];
                     work.extent_counter = '0;
                     if (acc_shift[15:0] == 16'd0) begin
                        finish     = 1'b1;
                        work.phase = ilep_pkg::PhTail;
                     end else begin
                        work.phase = ilep_pkg::PhExtIndex;
                     end
                  end
                  ilep_pkg::PhExtIndex: begin
                     work.phase = ilep_pkg::PhExtOffset;
                  end
                  ilep_pkg::PhExtOffset: begin
                     work.offset_value = acc_shift & ilep_pkg::AddrMask;
                     work.phase        = ilep_pkg::PhExtLength;
                  end
                  ilep_pkg::PhExtLength: begin
                     rec_vld             = 1'b1;
                     rec_off_op          = st.offset_value;
                     rec_len             = acc_shift & ilep_pkg::AddrMask;
                     rec_idx             = st.extent_counter;
                     work.extent_counter = st.extent_counter + 16'd1;
                     work.extents_left   = left_dec;
                     if (left_dec == 16'd0) begin
                        finish     = 1'b1;
                        work.phase = ilep_pkg::PhTail;
                     end else begin
                        work.phase = ilep_pkg::PhExtIndex;
                     end
                  end
                  default: begin
                     work.phase = st.phase;
                  end
               endcase
            end
         end
      endcase

      // Method field is absent outside versions one and two.
      if (work.phase == ilep_pkg::PhMethod && !ver12) begin
         work.current_method = 4'd0;
         work.phase          = ilep_pkg::PhDref;
      end
      // Base of zero width reads as zero.
      if (work.phase == ilep_pkg::PhBase && st.base_width == 4'd0) begin
         work.base_value = '0;
         work.phase      = ilep_pkg::PhExtCount;
      end
      if (work.phase == ilep_pkg::PhExtIndex && st.index_width == 4'd0) begin
         work.phase = ilep_pkg::PhExtOffset;
      end
      if (work.phase == ilep_pkg::PhExtOffset && st.offset_width == 4'd0) begin
         work.offset_value = '0;
         work.phase        = ilep_pkg::PhExtLength;
      end
      // Zero-length extent completes without a byte. When no extent field
      // takes a byte, all remaining extents of the item complete at once and
      // only the first one is reported.
      if (work.phase == ilep_pkg::PhExtLength && st.length_width == 4'd0) begin
         if (!rec_vld) begin
            rec_vld    = 1'b1;
            rec_off_op = work.offset_value;
            rec_len    = '0;
            rec_idx    = work.extent_counter;
         end
         if (zero_ext) begin
            work.extent_counter = work.extent_counter + work.extents_left;
            work.extents_left   = '0;
         end else begin
            work.extent_counter = work.extent_counter + 16'd1;
            work.extents_left   = work.extents_left - 16'd1;
         end
         if (work.extents_left == 16'd0) begin
            finish     = 1'b1;
            work.phase = ilep_pkg::PhTail;
         end else if (st.index_width == 4'd0) begin
            work.phase = ilep_pkg::PhExtOffset;
         end else begin
            work.phase = ilep_pkg::PhExtIndex;
         end
      end

      // End of an item: move to the next id or to the tail.
      items_dec = work.items_left - 32'd1;
      if (finish) begin
         work.items_left = items_dec;
         work.phase = (items_dec == 32'd0) ? ilep_pkg::PhTail : ilep_pkg::PhId;
      end
   end

   // Response assembly; unused fields read as zero.
   always_comb begin
      rsp.extent_valid   = rec_vld;
      rsp.item_id        = rec_vld ? st.current_id : 32'd0;
      rsp.extent_offset  = rec_vld ? ((st.base_value + rec_off_op) & ilep_pkg::AddrMask)
                                   : 64'd0;
      rsp.extent_length  = rec_len;
      rsp.from_item_data = rec_vld && (st.current_method == ilep_pkg::MethodIdat);
      rsp.extent_index   = rec_idx;
      rsp.done_res       = req.last_byte;
      rsp.status         = req.last_byte && (work.phase != ilep_pkg::PhTail);
   end

   assign rsp_present = rec_vld || req.last_byte;

   // The last byte returns the parser to its reset state for the next box.
   assign st_next = req.last_byte ? ilep_pkg::StateInit : work;

endmodule

[hw/rtl/item_location_extent_parser.sv]
// ----------------------------------------------------------------------------
// Item location extent parser
// Parses item location box payload bytes into per-extent records.
// ----------------------------------------------------------------------------
// The parser takes one payload byte per request, from the version byte on,
// and sustains one request per clock cycle. A request lands in an input
// register; once the output register is free the field state update for
// that byte runs in one pass and its response, if any, is written to the
// output register. The only stall is a held response: while a response
// waits and rsp_ready is low, the parser holds its byte. A byte yields a
// response when it completes an extent or carries the last-byte mark; the
// marked byte reports done with status ok or truncated and clears the
// parser for the next box.
module item_location_extent_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ilep_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ilep_pkg::rsp_type rsp_data
);

   logic                req_vld_ff;
   ilep_pkg::req_type   req_ff;
   ilep_pkg::state_type state_ff;
   ilep_pkg::state_type state_in;
   logic                rsp_vld_ff;
   ilep_pkg::rsp_type   rsp_ff;
   ilep_pkg::rsp_type   rsp_in;
   logic                rsp_present;
   logic                advance;

   // The held request is processed when the output register is free.
   assign advance   = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;

   ilep_step u_step (
      .st          (state_ff),
      .req         (req_ff),
      .st_next     (state_in),
      .rsp_present (rsp_present),
      .rsp         (rsp_in)
   );

   // Control and parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= ilep_pkg::StateInit;
      end else begin
         if (req_ready) begin
            req_vld_ff <= req_valid;
         end
         if (advance) begin
            state_ff   <= state_in;
            rsp_vld_ff <= rsp_present;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance && rsp_present) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // A held request is never overwritten before it is processed.
   assert property (@(posedge clock) disable iff (reset)
      (req_vld_ff && !advance) |=> (req_vld_ff && $stable(req_ff)))
      else $error("held request lost or changed");

   // The last byte leaves the parser at the start of a new header.
   assert property (@(posedge clock) disable iff (reset)
      (advance && req_ff.last_byte) |=>
         (state_ff.phase == ilep_pkg::PhHeader && state_ff.bytes_in_field == 4'd0))
      else $error("parser not cleared after last byte");

   // Truncation status only travels with the done report.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> rsp_data.done_res)
      else $error("status without done");

   // A response without an extent carries zero extent fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.extent_valid) |->
         (rsp_data.extent_offset == 64'd0 && rsp_data.extent_length == 64'd0 &&
          rsp_data.item_id == 32'd0))
      else $error("extent fields set without an extent");
`endif

endmodule

[bench/ilep_extent_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Item location extent checker
// Watches the request and response channels of the extent parser, parses
// each accepted payload byte with its own copy of the field state machine,
// and compares every response, field by field, with the oldest predicted
// record.
// ----------------------------------------------------------------------------
module ilep_extent_checker
   import ilep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int unsigned error_count,
   output int unsigned pending,
   output int unsigned extents_checked,
   output int unsigned boxes_checked
);

   state_type   parse_state;
   rsp_type     built_record;
   rsp_type     expected_records[$];
   int unsigned mismatches   = 0;
   int unsigned extent_total = 0;
   int unsigned box_total    = 0;

   // Versions 1 and 2 carry the method field and the index width.
   function automatic logic has_method();
      return parse_state.box_version == Version1 || parse_state.box_version == Version2;
   endfunction

   // Number of payload bytes the field of a given phase occupies.
   function automatic logic [3:0] field_len(input phase_type ph);
      case (ph)
         PhCount, PhId: return (parse_state.box_version < Version2) ? 4'd2 : 4'd4;
         PhMethod:      return has_method() ? 4'd2 : 4'd0;
         PhDref:        return 4'd2;
         PhBase:        return parse_state.base_width;
         PhExtCount:    return 4'd2;
         PhExtIndex:    return parse_state.index_width;
         PhExtOffset:   return parse_state.offset_width;
         PhExtLength:   return parse_state.length_width;
         default:       return 4'd1;
      endcase
   endfunction

   function automatic void enter_phase(input phase_type ph);
      parse_state.phase          = ph;
      parse_state.accumulator    = '0;
      parse_state.bytes_in_field = '0;
   endfunction

   function automatic void close_item();
      parse_state.items_left = parse_state.items_left - 32'd1;
      enter_phase(parse_state.items_left == 0 ? PhTail : PhId);
   endfunction

   // Acts on a field whose last byte has arrived (or that takes no bytes).
   function automatic void complete_field();
      logic [63:0] acc;
      acc = parse_state.accumulator;
      case (parse_state.phase)
         PhCount: begin
            parse_state.items_left = acc[31:0];
            enter_phase(parse_state.items_left == 0 ? PhTail : PhId);
         end
         PhId: begin
            parse_state.current_id     = acc[31:0];
            parse_state.current_method = '0;
            enter_phase(PhMethod);
         end
         PhMethod: begin
            parse_state.current_method = acc[3:0] & MethodMask[3:0];
            enter_phase(PhDref);
         end
         PhDref: begin
            enter_phase(PhBase);
         end
         PhBase: begin
            parse_state.base_value = acc & AddrMask;
            enter_phase(PhExtCount);
         end
         PhExtCount: begin
            parse_state.extents_left   = acc[15:0];
            parse_state.extent_counter = '0;
            if (parse_state.extents_left == 0) close_item();
            else enter_phase(PhExtIndex);
         end
         PhExtIndex: begin
            enter_phase(PhExtOffset);
         end
         PhExtOffset: begin
            parse_state.offset_value = acc & AddrMask;
            enter_phase(PhExtLength);
         end
         PhExtLength: begin
            // Only the first extent completed by a byte is reported.
            if (!built_record.extent_valid) begin
               built_record.extent_valid   = 1'b1;
               built_record.item_id        = parse_state.current_id;
               built_record.extent_offset  =
                  (parse_state.base_value + parse_state.offset_value) & AddrMask;
               built_record.extent_length  = acc & AddrMask;
               built_record.from_item_data = parse_state.current_method == MethodIdat;
               built_record.extent_index   = parse_state.extent_counter;
            end
            parse_state.extent_counter = parse_state.extent_counter + 16'd1;
            parse_state.extents_left   = parse_state.extents_left - 16'd1;
            if (parse_state.extents_left == 0) close_item();
            else enter_phase(PhExtIndex);
         end
         default: begin
         end
      endcase
   endfunction

   // Advances the parse by one payload byte and queues the record it causes.
   function automatic void parse_byte(input req_type r);
      logic all_read;
      built_record = '0;
      if (parse_state.phase == PhHeader) begin
         if (parse_state.bytes_in_field == HdrVersionByte)
            parse_state.box_version = r.byte_value;
         if (parse_state.bytes_in_field == HdrSizeByte) begin
            parse_state.offset_width = r.byte_value[7:4];
            parse_state.length_width = r.byte_value[3:0];
         end
         if (parse_state.bytes_in_field == HdrBaseByte) begin
            parse_state.base_width  = r.byte_value[7:4];
            parse_state.index_width = has_method() ? r.byte_value[3:0] : 4'd0;
            enter_phase(PhCount);
         end else begin
            parse_state.bytes_in_field = parse_state.bytes_in_field + 4'd1;
         end
      end else if (parse_state.phase != PhTail) begin
         parse_state.accumulator    = {parse_state.accumulator[55:0], r.byte_value};
         parse_state.bytes_in_field = parse_state.bytes_in_field + 4'd1;
         if (parse_state.bytes_in_field >= field_len(parse_state.phase)) complete_field();
         // Fields of zero width complete at once.
         while (parse_state.phase != PhHeader && parse_state.phase != PhTail &&
                field_len(parse_state.phase) == 0)
            complete_field();
      end
      all_read = parse_state.phase == PhTail;
      if (built_record.extent_valid || r.last_byte) begin
         built_record.done_res = r.last_byte;
         built_record.status   = r.last_byte && !all_read;
         expected_records.push_back(built_record);
      end
      if (r.last_byte) parse_state = StateInit;
   endfunction

   task automatic report_error(input string msg);
      mismatches++;
      $display("[%0t] ERROR: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_error($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
   endtask

   // Compares one accepted response with the oldest predicted record.
   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (expected_records.size() == 0) begin
         report_error("response arrived with no record expected");
         return;
      end
      want = expected_records.pop_front();
      check_field("extent_valid", 64'(got.extent_valid), 64'(want.extent_valid));
      check_field("item_id", 64'(got.item_id), 64'(want.item_id));
      check_field("extent_offset", got.extent_offset, want.extent_offset);
      check_field("extent_length", got.extent_length, want.extent_length);
      check_field("from_item_data", 64'(got.from_item_data), 64'(want.from_item_data));
      check_field("extent_index", 64'(got.extent_index), 64'(want.extent_index));
      check_field("done_res", 64'(got.done_res), 64'(want.done_res));
      check_field("status", 64'(got.status), 64'(want.status));
      if (want.extent_valid) extent_total++;
      if (want.done_res) box_total++;
   endtask

   // Responses are checked before the request of the same edge is parsed.
   always @(posedge clock) begin
      if (reset) begin
         parse_state = StateInit;
         expected_records.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_response(rsp_data);
         if (req_valid && req_ready) parse_byte(req_data);
      end
      pending         <= expected_records.size();
      error_count     <= mismatches;
      extents_checked <= extent_total;
      boxes_checked   <= box_total;
   end

endmodule

[bench/item_location_extent_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Item location extent parser testbench
// Feeds location box payloads, well-formed with random content, truncated,
// padded with trailing bytes, or pure noise, through the parser under random
// request and response idling, while the extent checker verifies every
// response.
// ----------------------------------------------------------------------------
module item_location_extent_parser_tb;
   import ilep_pkg::*;

   localparam int unsigned CycleLimit   = 200000;
   localparam int unsigned RandomBytes  = 450;
   localparam int unsigned SettleCycles = 10;
   localparam logic [7:0]  Version0     = 8'd0;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   int unsigned error_count;
   int unsigned pending;
   int unsigned extents_checked;
   int unsigned boxes_checked;
   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   int unsigned bytes_sent  = 0;
   int unsigned boxes_sent  = 0;
   int unsigned cycle_count = 0;
   logic [7:0]  box_bytes[$];

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   item_location_extent_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ilep_extent_checker extent_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .error_count     (error_count),
      .pending         (pending),
      .extents_checked (extents_checked),
      .boxes_checked   (boxes_checked)
   );

   // Response back-pressure at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Field widths lean toward the usual sizes, with the odd wide one.
   function automatic logic [3:0] pick_width();
      case ($urandom_range(9))
         0, 1:    return 4'd0;
         2, 3:    return 4'($urandom_range(2, 1));
         4, 5:    return 4'd4;
         6, 7:    return 4'd8;
         default: return 4'($urandom_range(15, 9));
      endcase
   endfunction

   function automatic logic [63:0] field_value();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Appends a big-endian field; bytes above the low eight are random.
   task automatic add_field(input int unsigned nbytes, input logic [63:0] value);
      for (int i = int'(nbytes) - 1; i >= 0; i--)
         box_bytes.push_back(i < 8 ? value[8*i +: 8] : 8'($urandom));
   endtask

   // Builds a box payload: header, item count, then items and their extents.
   task automatic build_box(input logic [7:0] ver, input logic [3:0] off_w,
                            input logic [3:0] len_w, input logic [3:0] base_w,
                            input logic [3:0] idx_nib, input int unsigned claim,
                            input int unsigned n_items, input int unsigned min_ext,
                            input int unsigned max_ext);
      int unsigned id_len;
      int unsigned idx_len;
      int unsigned n_ext;
      logic        with_method;
      with_method = ver == Version1 || ver == Version2;
      id_len      = (ver < Version2) ? 2 : 4;
      idx_len     = with_method ? idx_nib : 0;
      box_bytes.delete();
      box_bytes.push_back(ver);
      repeat (3) box_bytes.push_back(8'($urandom));
      box_bytes.push_back({off_w, len_w});
      box_bytes.push_back({base_w, idx_nib});
      add_field(id_len, 64'(claim));
      repeat (n_items) begin
         n_ext = $urandom_range(max_ext, min_ext);
         add_field(id_len, field_value());
         if (with_method)
            add_field(2, ($urandom_range(3) == 0) ? 64'($urandom) : 64'($urandom_range(2)));
         add_field(2, 64'($urandom));
         add_field(base_w, field_value());
         add_field(2, 64'(n_ext));
         repeat (n_ext) begin
            add_field(idx_len, field_value());
            add_field(off_w, field_value());
            add_field(len_w, field_value());
         end
      end
   endtask

   // Presents one request and holds it until accepted.
   task automatic send_byte(input logic [7:0] value, input logic mark);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{byte_value: value, last_byte: mark};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_box();
      foreach (box_bytes[i]) send_byte(box_bytes[i], i == box_bytes.size() - 1);
      boxes_sent++;
   endtask

   // Holds off requests until every predicted response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // One random box: mostly well formed, some cut short, padded or noise.
   task automatic random_box();
      logic [7:0]  ver;
      logic [3:0]  off_w;
      logic [3:0]  len_w;
      logic [3:0]  base_w;
      logic [3:0]  idx_nib;
      int unsigned n_items;
      int unsigned claim;
      int unsigned shape;
      int unsigned keep;
      case ($urandom_range(9))
         0, 1, 2: ver = Version0;
         3, 4, 5: ver = Version1;
         6, 7:    ver = Version2;
         default: ver = 8'($urandom);
      endcase
      off_w   = pick_width();
      len_w   = pick_width();
      base_w  = pick_width();
      idx_nib = pick_width();
      if ($urandom_range(9) == 0) begin
         off_w   = '0;
         len_w   = '0;
         idx_nib = '0;
      end
      n_items = $urandom_range(3);
      claim   = n_items;
      // An item count larger than the items that follow leaves the box short.
      if ($urandom_range(9) == 0)
         claim = (ver < Version2) ? $urandom_range(16'hFFFF, n_items + 1)
                                  : $urandom_range(32'hFFFF_FFFF, n_items + 1);
      build_box(ver, off_w, len_w, base_w, idx_nib, claim, n_items, 0, 3);
      shape = $urandom_range(99);
      if (shape < 12) begin
         keep = $urandom_range(box_bytes.size(), 1);
         while (box_bytes.size() > keep) void'(box_bytes.pop_back());
      end else if (shape < 22) begin
         repeat ($urandom_range(4, 1)) box_bytes.push_back(8'($urandom));
      end else if (shape < 27) begin
         box_bytes.delete();
         repeat ($urandom_range(12, 1)) box_bytes.push_back(8'($urandom));
      end
      send_box();
      if ($urandom_range(7) == 0) drain();
   endtask

   task automatic random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
      int unsigned target;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      target      = bytes_sent + RandomBytes / 3;
      while (bytes_sent < target) random_box();
      drain();
   endtask

   // Stimulus and verdict.
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Version 1 with zero index, offset and length widths: one item whose
      // three extents all complete on the last byte of the extent count.
      build_box(Version1, '0, '0, '0, '0, 1, 1, 3, 3);
      send_box();
      // A lone all-ones byte carrying the mark: truncated inside the header.
      box_bytes.delete();
      box_bytes.push_back(8'hFF);
      send_box();
      // Empty version 0 box with maximum size nibbles, then trailing bytes.
      build_box(Version0, 4'hF, 4'hF, 4'hF, 4'hF, 0, 0, 0, 0);
      box_bytes.push_back(8'h00);
      box_bytes.push_back(8'hFF);
      send_box();
      drain();

      random_phase(6, 58);
      random_phase(58, 6);
      random_phase(0, 0);

      repeat (SettleCycles) @(posedge clock);
      $display("Sent %0d boxes in %0d payload bytes; checked %0d extent records and %0d box reports.",
               boxes_sent, bytes_sent, extents_checked, boxes_checked);
      if (error_count == 0) begin
         $display("item_location_extent_parser verification clean");
      end else begin
         $display("item_location_extent_parser verification failed");
      end
      $finish;
   end

   // Watchdog on total run length.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run exceeded %0d cycles.", CycleLimit);
      $display("item_location_extent_parser verification failed");
      $finish;
   end

endmodule

[files.f]
hw/rtl/ilep_pkg.sv
hw/rtl/ilep_step.sv
hw/rtl/item_location_extent_parser.sv
bench/ilep_extent_checker.sv
bench/item_location_extent_parser_tb.sv
